@@ rtl/dfpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_pkg
// Shared types and constants of the depth forest pixel classifier.
// ----------------------------------------------------------------------------
package dfpc_pkg;

  typedef enum logic [1:0] {
    OP_DEPTH    = 2'd0,
    OP_NODE     = 2'd1,
    OP_LEAF     = 2'd2,
    OP_CLASSIFY = 2'd3
  } op_t;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LABEL_COUNT  = 3'd2;
  localparam logic [2:0] REG_TREE_COUNT   = 3'd3;
  localparam logic [2:0] REG_BACKGROUND   = 3'd4;

  // pixel * depth + offset fits in 26 signed bits; the tree sum fits as well
  localparam int NUMW = 26;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic        [11:0] leaf_ref;
    logic signed [17:0] thr;
    logic signed [23:0] vy;
    logic signed [23:0] vx;
    logic signed [23:0] uy;
    logic signed [23:0] ux;
  } node_t;

  typedef struct packed {
    op_t                op;
    logic               wr_ok;
    logic        [15:0] sat;
    logic        [1:0]  tree_sel;
    logic        [11:0] entry_index;
    logic        [4:0]  label_sel;
    logic        [7:0]  pos_x;
    logic        [7:0]  pos_y;
    node_t              node;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } front_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

@@ rtl/dfpc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dfpc_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_divider
// Radix-2 restoring divider: signed numerator, unsigned nonzero divisor,
// quotient truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module dfpc_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [dfpc_pkg::NUMW-1:0] num,
  input  logic        [15:0]               den,
  output logic                             done,
  output logic signed [dfpc_pkg::NUMW-1:0] quo
);

  localparam int W  = dfpc_pkg::NUMW;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  mag;
  logic [15:0]   rem;
  logic [15:0]   dv;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          fin;
  logic [16:0]   trial;

  assign trial = {rem, mag[W-1]};
  assign done  = fin && (cnt == '0);
  assign quo   = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      fin <= 1'b0;
    end else if (start) begin
      cnt <= CW'(W);
      fin <= 1'b1;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[W-1];
      mag <= num[W-1] ? W'(-num) : W'(num);
      rem <= '0;
      dv  <= den;
    end else if (cnt != '0) begin
      if (trial >= {1'b0, dv}) begin
        rem <= 16'(trial - {1'b0, dv});
        mag <= {mag[W-2:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        mag <= {mag[W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/dfpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_front
// Input side: unpacks and range-checks items, then holds them in a short
// queue for the execution side.
// ----------------------------------------------------------------------------
module dfpc_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int TREE_DEPTH = 12,
  parameter int MAX_TREES  = 4,
  parameter int MAX_LABELS = 32,
  parameter int MAX_LEAVES = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [167:0]          in_data,
  input  logic [1:0]            in_user,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dfpc_pkg::item_t       out_item,
  output dfpc_pkg::front_stat_t stat
);

  localparam int PW = (dfpc_pkg::QDEPTH > 1) ? $clog2(dfpc_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(dfpc_pkg::QDEPTH + 1);

  dfpc_pkg::item_t   dec;
  dfpc_pkg::item_t   q [dfpc_pkg::QDEPTH];
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     rptr;
  logic [CW-1:0]     count;
  logic signed [17:0] data;
  logic              push;
  logic              pop;

  assign data = $signed(in_data[148:131]);

  always_comb begin
    dec.op               = dfpc_pkg::op_t'(in_user);
    dec.tree_sel         = in_data[1:0];
    dec.entry_index      = in_data[13:2];
    dec.label_sel        = in_data[18:14];
    dec.pos_x            = in_data[26:19];
    dec.pos_y            = in_data[34:27];
    dec.node.ux          = $signed(in_data[58:35]);
    dec.node.uy          = $signed(in_data[82:59]);
    dec.node.vx          = $signed(in_data[106:83]);
    dec.node.vy          = $signed(in_data[130:107]);
    dec.node.thr         = data;
    dec.node.leaf_ref    = in_data[160:149];
    if (data < 0) begin
      dec.sat = 16'd0;
    end else if (data > 18'sd65535) begin
      dec.sat = 16'hFFFF;
    end else begin
      dec.sat = data[15:0];
    end
    unique case (dec.op)
      dfpc_pkg::OP_DEPTH: dec.wr_ok = (32'(dec.pos_x) < MAX_WIDTH) &&
                                      (32'(dec.pos_y) < MAX_HEIGHT);
      dfpc_pkg::OP_NODE:  dec.wr_ok = (32'(dec.tree_sel) < MAX_TREES) &&
                                      (32'(dec.entry_index) < (2 ** TREE_DEPTH));
      dfpc_pkg::OP_LEAF:  dec.wr_ok = (32'(dec.tree_sel) < MAX_TREES) &&
                                      (32'(dec.entry_index) < MAX_LEAVES) &&
                                      (32'(dec.label_sel) < MAX_LABELS);
      default:            dec.wr_ok = 1'b0;
    endcase
  end

  assign in_ready   = (count != CW'(dfpc_pkg::QDEPTH));
  assign out_valid  = (count != '0);
  assign out_item   = q[rptr];
  assign push       = in_valid && in_ready;
  assign pop        = out_valid && out_ready;
  assign stat.full  = !in_ready;
  assign stat.empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(dfpc_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(dfpc_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= dec;
    end
  end

endmodule

@@ rtl/dfpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_back
// Execution side: performs store writes and walks the trees of a classify
// item, accumulates leaf tables and emits the averaged label results.
// ----------------------------------------------------------------------------
module dfpc_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int TREE_DEPTH = 12,
  parameter int MAX_TREES  = 4,
  parameter int MAX_LABELS = 32,
  parameter int MAX_LEAVES = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  dfpc_pkg::item_t      item,
  input  logic [8:0]           frame_width,
  input  logic [8:0]           frame_height,
  input  logic [5:0]           label_count,
  input  logic [2:0]           tree_count,
  input  logic [15:0]          background_depth,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [4:0]           res_label,
  output logic [15:0]          res_prob,
  output logic                 res_last,
  output logic                 res_over,
  output dfpc_pkg::back_stat_t stat
);

  localparam int NUMW = dfpc_pkg::NUMW;
  localparam int TW   = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int LFW  = $clog2(MAX_LEAVES);
  localparam int LBW  = $clog2(MAX_LABELS);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int FAW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int NAW  = TW + TREE_DEPTH;
  localparam int LAW  = TW + LFW + LBW;
  localparam int NTW  = $clog2(MAX_TREES + 1);
  localparam int LCW  = $clog2(MAX_LABELS + 1);
  localparam int SUMW = 16 + $clog2(MAX_TREES + 1);

  typedef enum logic [13:0] {
    S_IDLE      = 14'h0001,
    S_WRITE     = 14'h0002,
    S_CTR       = 14'h0004,
    S_CTR_W     = 14'h0008,
    S_NODE      = 14'h0010,
    S_NODE_W    = 14'h0020,
    S_DIVST     = 14'h0040,
    S_DIV       = 14'h0080,
    S_PU        = 14'h0100,
    S_PV        = 14'h0200,
    S_CMP       = 14'h0400,
    S_LEAF_RD   = 14'h0800,
    S_LEAF_ACC  = 14'h1000,
    S_EMIT_DIV  = 14'h2000
  } state_t;

  state_t                state;
  logic                  emit_wait;
  dfpc_pkg::item_t       cur;
  logic [15:0]           d;
  logic [NTW-1:0]        t;
  logic [TREE_DEPTH-1:0] id;
  logic                  over;
  dfpc_pkg::node_t       node;
  logic [LFW-1:0]        leaf_idx;
  logic [LCW-1:0]        l;
  logic [15:0]           u_val;
  logic [SUMW-1:0]       sums [MAX_LABELS];

  logic [NTW-1:0] nt;
  logic [LCW-1:0] nl;
  logic [8:0]     w;
  logic [8:0]     h;

  logic [15:0]          frame_rdata;
  logic [FAW-1:0]       frame_raddr;
  logic [FAW-1:0]       pos_addr;
  dfpc_pkg::node_t      node_rdata;
  logic [15:0]          leaf_rdata;

  logic [23:0]            prod_x;
  logic [23:0]            prod_y;
  logic                   div_start;
  logic                   emit_start;
  logic                   emit_fire;
  logic signed [NUMW-1:0] num0;
  logic [15:0]            den0;
  logic signed [NUMW-1:0] q_ux, q_uy, q_vx, q_vy;
  logic                   done0, done1, done2, done3;
  logic                   u_in, v_in;
  logic [FAW-1:0]         u_addr, v_addr;
  logic [15:0]            v_cur;
  logic signed [18:0]     diff;
  logic [TREE_DEPTH+1:0]  child;
  logic                   child_over;
  logic [11:0]            lidx;
  logic                   last_tree;
  logic                   last_label;
  logic                   ctr_ok;

  // register clamping
  always_comb begin
    if (tree_count == '0) begin
      nt = NTW'(1);
    end else if (32'(tree_count) > MAX_TREES) begin
      nt = NTW'(MAX_TREES);
    end else begin
      nt = NTW'(tree_count);
    end
    if (label_count == '0) begin
      nl = LCW'(1);
    end else if (32'(label_count) > MAX_LABELS) begin
      nl = LCW'(MAX_LABELS);
    end else begin
      nl = LCW'(label_count);
    end
    w = (32'(frame_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : frame_width;
    h = (32'(frame_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : frame_height;
  end

  assign ctr_ok     = (32'(cur.pos_x) < MAX_WIDTH) && (32'(cur.pos_y) < MAX_HEIGHT);
  assign pos_addr   = FAW'(32'(cur.pos_y) * MAX_WIDTH + 32'(cur.pos_x));
  assign last_tree  = (t + 1'b1 == nt);
  assign last_label = (l == nl - 1'b1);

  // probe positions
  assign prod_x = cur.pos_x * d;
  assign prod_y = cur.pos_y * d;
  assign div_start  = (state == S_DIVST);
  assign emit_start = (state == S_EMIT_DIV) && !emit_wait;
  assign emit_fire  = (state == S_EMIT_DIV) && emit_wait && done0 &&
                      (!res_valid || res_ready);
  assign num0 = emit_start ? NUMW'($signed({1'b0, sums[l[LBW-1:0]]}))
                           : NUMW'($signed({1'b0, prod_x})) + NUMW'(node.ux);
  assign den0 = emit_start ? 16'(nt) : d;

  dfpc_divider u_div_ux (
    .clk(clk), .rst(rst), .start(div_start || emit_start), .num(num0), .den(den0),
    .done(done0), .quo(q_ux)
  );
  dfpc_divider u_div_uy (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NUMW'($signed({1'b0, prod_y})) + NUMW'(node.uy)), .den(d),
    .done(done1), .quo(q_uy)
  );
  dfpc_divider u_div_vx (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NUMW'($signed({1'b0, prod_x})) + NUMW'(node.vx)), .den(d),
    .done(done2), .quo(q_vx)
  );
  dfpc_divider u_div_vy (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NUMW'($signed({1'b0, prod_y})) + NUMW'(node.vy)), .den(d),
    .done(done3), .quo(q_vy)
  );

  assign u_in = !q_ux[NUMW-1] && (q_ux < $signed(NUMW'(w))) &&
                !q_uy[NUMW-1] && (q_uy < $signed(NUMW'(h)));
  assign v_in = !q_vx[NUMW-1] && (q_vx < $signed(NUMW'(w))) &&
                !q_vy[NUMW-1] && (q_vy < $signed(NUMW'(h)));
  assign u_addr = FAW'(32'(q_uy[YW-1:0]) * MAX_WIDTH + 32'(q_ux[XW-1:0]));
  assign v_addr = FAW'(32'(q_vy[YW-1:0]) * MAX_WIDTH + 32'(q_vx[XW-1:0]));

  assign v_cur = (d == '0 || !v_in) ? background_depth : frame_rdata;
  assign diff  = $signed({3'b000, u_val}) - $signed({3'b000, v_cur});
  // right child 2i+2 is formed as 2(i+1) so the top node cannot wrap
  assign child = (diff < 19'(node.thr)) ? {1'b0, id, 1'b1}
                                        : {{1'b0, id} + 1'b1, 1'b0};
  assign child_over = |child[TREE_DEPTH+1:TREE_DEPTH];
  assign lidx  = node_rdata.leaf_ref - 1'b1;

  always_comb begin
    unique case (state)
      S_CTR:   frame_raddr = pos_addr;
      S_PU:    frame_raddr = u_addr;
      default: frame_raddr = v_addr;
    endcase
  end

  dfpc_ram #(.WIDTH(16), .DEPTH(2 ** FAW)) u_frame (
    .clk(clk),
    .we(state == S_WRITE && cur.op == dfpc_pkg::OP_DEPTH && cur.wr_ok),
    .waddr(pos_addr), .wdata(cur.sat),
    .raddr(frame_raddr), .rdata(frame_rdata)
  );

  dfpc_ram #(.WIDTH($bits(dfpc_pkg::node_t)), .DEPTH(2 ** NAW)) u_nodes (
    .clk(clk),
    .we(state == S_WRITE && cur.op == dfpc_pkg::OP_NODE && cur.wr_ok),
    .waddr({TW'(cur.tree_sel), TREE_DEPTH'(cur.entry_index)}), .wdata(cur.node),
    .raddr({t[TW-1:0], id}), .rdata(node_rdata)
  );

  dfpc_ram #(.WIDTH(16), .DEPTH(2 ** LAW)) u_leaves (
    .clk(clk),
    .we(state == S_WRITE && cur.op == dfpc_pkg::OP_LEAF && cur.wr_ok),
    .waddr({TW'(cur.tree_sel), LFW'(cur.entry_index), LBW'(cur.label_sel)}),
    .wdata(cur.sat),
    .raddr({t[TW-1:0], leaf_idx, l[LBW-1:0]}), .rdata(leaf_rdata)
  );

  assign item_ready = (state == S_IDLE);
  assign stat.busy  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_wait <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= (item.op == dfpc_pkg::OP_CLASSIFY) ? S_CTR : S_WRITE;
          end
        end
        S_WRITE:  state <= S_IDLE;
        S_CTR:    state <= S_CTR_W;
        S_CTR_W:  state <= S_NODE;
        S_NODE:   state <= S_NODE_W;
        S_NODE_W: begin
          if (node_rdata.leaf_ref != '0) begin
            if (32'(lidx) < MAX_LEAVES) begin
              state <= S_LEAF_RD;
            end else if (last_tree) begin
              state <= S_EMIT_DIV;
            end else begin
              state <= S_NODE;
            end
          end else if (d == '0) begin
            state <= S_CMP;
          end else begin
            state <= S_DIVST;
          end
        end
        S_DIVST: state <= S_DIV;
        S_DIV: begin
          if (done0 && done1 && done2 && done3) begin
            state <= S_PU;
          end
        end
        S_PU: state <= S_PV;
        S_PV: state <= S_CMP;
        S_CMP: begin
          if (!child_over) begin
            state <= S_NODE;
          end else if (last_tree) begin
            state <= S_EMIT_DIV;
          end else begin
            state <= S_NODE;
          end
        end
        S_LEAF_RD: state <= S_LEAF_ACC;
        S_LEAF_ACC: begin
          if (!last_label) begin
            state <= S_LEAF_RD;
          end else if (last_tree) begin
            state <= S_EMIT_DIV;
          end else begin
            state <= S_NODE;
          end
        end
        S_EMIT_DIV: begin
          if (!emit_wait) begin
            emit_wait <= 1'b1;
          end else if (emit_fire) begin
            emit_wait <= 1'b0;
            if (last_label) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur <= item;
      end
      S_CTR_W: begin
        d    <= ctr_ok ? frame_rdata : 16'd0;
        t    <= '0;
        id   <= '0;
        over <= 1'b0;
        for (int i = 0; i < MAX_LABELS; i++) begin
          sums[i] <= '0;
        end
      end
      S_NODE_W: begin
        node     <= node_rdata;
        leaf_idx <= LFW'(lidx);
        l        <= '0;
        u_val    <= background_depth;
        if (node_rdata.leaf_ref != '0 && 32'(lidx) >= MAX_LEAVES) begin
          t  <= t + 1'b1;
          id <= '0;
        end
      end
      S_PV: begin
        u_val <= u_in ? frame_rdata : background_depth;
      end
      S_CMP: begin
        if (!child_over) begin
          id <= child[TREE_DEPTH-1:0];
        end else begin
          over <= 1'b1;
          t    <= t + 1'b1;
          id   <= '0;
          l    <= '0;
        end
      end
      S_LEAF_ACC: begin
        sums[l[LBW-1:0]] <= sums[l[LBW-1:0]] + SUMW'(leaf_rdata);
        if (!last_label) begin
          l <= l + 1'b1;
        end else begin
          t  <= t + 1'b1;
          id <= '0;
          l  <= '0;
        end
      end
      S_EMIT_DIV: begin
        if (emit_fire) begin
          res_label <= 5'(l);
          res_prob  <= 16'(q_ux);
          res_last  <= last_label;
          res_over  <= over;
          l         <= l + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/depth_forest_pixel_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_forest_pixel_classifier_unit
// Decision forest pixel classifier over a stored depth frame.
// ----------------------------------------------------------------------------
// Write items (depth pixel, tree node, leaf probability) pass through a single
// write state in the execution side. The run time of a classify item grows with
// the split nodes visited with a nonzero centre depth, those visited with a zero
// centre depth, the trees whose walk reaches a leaf node, the trees reaching a
// valid leaf, the label count used for leaf accumulation, the label count
// emitted and any output stall. The run time is set by the four bit-serial probe
// dividers (one quotient bit per cycle, 26 bits) and by the single shared divider
// that averages each label over the tree count. A two-entry queue lets input
// items be accepted while a classify is running.
// ----------------------------------------------------------------------------
module depth_forest_pixel_classifier_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int TREE_DEPTH = 12,
  parameter int MAX_TREES  = 4,
  parameter int MAX_LABELS = 32,
  parameter int MAX_LEAVES = 2048
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tree_sel, entry_index, label_sel, pos_x, pos_y, offset_ux, offset_uy,
  // offset_vx, offset_vy, data_word, leaf_ref
  input  logic [167:0] s_axis_tdata,
  // opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // label, probability
  output logic [23:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // overrun
  output logic         m_axis_tuser
);

  logic [8:0]  frame_width;
  logic [8:0]  frame_height;
  logic [5:0]  label_count;
  logic [2:0]  tree_count;
  logic [15:0] background_depth;

  logic                  q_valid;
  logic                  q_ready;
  dfpc_pkg::item_t       q_item;
  dfpc_pkg::front_stat_t fstat;
  dfpc_pkg::back_stat_t  bstat;
  logic [4:0]            res_label;
  logic [15:0]           res_prob;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= 9'd256;
      frame_height     <= 9'd256;
      label_count      <= 6'd32;
      tree_count       <= 3'd4;
      background_depth <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfpc_pkg::REG_FRAME_WIDTH:  frame_width      <= cfg_data[8:0];
        dfpc_pkg::REG_FRAME_HEIGHT: frame_height     <= cfg_data[8:0];
        dfpc_pkg::REG_LABEL_COUNT:  label_count      <= cfg_data[5:0];
        dfpc_pkg::REG_TREE_COUNT:   tree_count       <= cfg_data[2:0];
        dfpc_pkg::REG_BACKGROUND:   background_depth <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dfpc_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .TREE_DEPTH(TREE_DEPTH),
    .MAX_TREES(MAX_TREES), .MAX_LABELS(MAX_LABELS), .MAX_LEAVES(MAX_LEAVES)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_user(s_axis_tuser),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item),
    .stat(fstat)
  );

  dfpc_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .TREE_DEPTH(TREE_DEPTH),
    .MAX_TREES(MAX_TREES), .MAX_LABELS(MAX_LABELS), .MAX_LEAVES(MAX_LEAVES)
  ) u_back (
    .clk(clk), .rst(rst),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .frame_width(frame_width), .frame_height(frame_height),
    .label_count(label_count), .tree_count(tree_count),
    .background_depth(background_depth),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_label(res_label), .res_prob(res_prob),
    .res_last(m_axis_tlast), .res_over(m_axis_tuser),
    .stat(bstat)
  );

  assign m_axis_tdata = {3'b000, res_prob, res_label};

  // a result that is not the last of its run means the walk is still emitting
  a_run_in_progress: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> bstat.busy)
    else $error("non-final result while execution side idle");

  // an idle execution side takes a queued item at once
  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    !bstat.busy && !fstat.empty |=> bstat.busy)
    else $error("queued item not taken by idle execution side");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth forest pixel classifier.
// Loads frames, trees and leaf tables, classifies pixels under several register
// settings and compares every label score with a built-in forest predictor.
// Classify items whose walk would touch an unloaded entry are never sent.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 4000;

  typedef struct {
    dfpc_pkg::op_t op;
    logic [1:0]  tsel;
    logic [11:0] idx;
    logic [4:0]  lsel;
    logic [7:0]  px, py;
    logic [23:0] ux, uy, vx, vy;
    logic [17:0] dw;
    logic [11:0] lref;
  } req_t;

  typedef struct {
    logic [4:0]  label;
    logic [15:0] prob;
    logic        last, over;
  } score_t;

  typedef struct {
    int          ux, uy, vx, vy, thr;
    int unsigned lref;
  } fnode_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  depth_forest_pixel_classifier_unit dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  bit [15:0] depth_mem [65536];
  bit        depth_wr [65536];
  fnode_t    node_mem [4][4096];
  bit        node_wr [4][4096];
  bit [15:0] prob_mem [4][2048][32];
  bit        prob_wr [4][2048][32];
  int unsigned r_w = 256, r_h = 256, r_lc = 32, r_tc = 4, r_bg = 65535;

  req_t   pending_q[$];
  score_t score_q[$];
  int     errors = 0;
  int     idle_mode = 0;     // 0: sender light, receiver heavy; 1: swapped; 2: none
  int     hold_ticket = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     stall = 0;

  function automatic bit [15:0] clip16(logic signed [17:0] v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic longint probe_depth(longint px, longint py, longint d, longint ox,
                                         longint oy, inout bit clean);
    longint w, h, qx, qy;
    w = (r_w > 256) ? 256 : r_w;
    h = (r_h > 256) ? 256 : r_h;
    if (d == 0) return r_bg;
    qx = (px * d + ox) / d;
    qy = (py * d + oy) / d;
    if (qx < 0 || qx >= w || qy < 0 || qy >= h) return r_bg;
    if (!depth_wr[qy * 256 + qx]) clean = 0;
    return depth_mem[qy * 256 + qx];
  endfunction

  // returns 0 if the walk would read an entry that was never loaded
  function automatic bit forest_eval(int px, int py, output longint unsigned sums[32],
                                     output bit over);
    int nt, nl, t, l;
    longint d, u, v;
    int unsigned id, child, leaf;
    bit ok, clean;
    nt = (r_tc < 1) ? 1 : (r_tc > 4) ? 4 : r_tc;
    nl = (r_lc < 1) ? 1 : (r_lc > 32) ? 32 : r_lc;
    over = 0;
    clean = 1;
    for (l = 0; l < 32; l++) sums[l] = 0;
    if (!depth_wr[py * 256 + px]) return 0;
    d = depth_mem[py * 256 + px];
    for (t = 0; t < nt; t++) begin
      id = 0;
      ok = 1;
      while (1) begin
        if (!node_wr[t][id]) return 0;
        if (node_mem[t][id].lref != 0) break;
        u = probe_depth(px, py, d, node_mem[t][id].ux, node_mem[t][id].uy, clean);
        v = probe_depth(px, py, d, node_mem[t][id].vx, node_mem[t][id].vy, clean);
        if (!clean) return 0;
        child = (u - v < node_mem[t][id].thr) ? 2 * id + 1 : 2 * id + 2;
        if (child >= 4096) begin
          over = 1;
          ok = 0;
          break;
        end
        id = child;
      end
      if (ok) begin
        leaf = node_mem[t][id].lref - 1;
        if (leaf < 2048)
          for (l = 0; l < nl; l++) begin
            if (!prob_wr[t][leaf][l]) return 0;
            sums[l] += prob_mem[t][leaf][l];
          end
      end
    end
    return 1;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.op = dfpc_pkg::op_t'($urandom_range(0, 3));
    r.tsel = $urandom;
    r.idx = $urandom;
    r.lsel = $urandom;
    r.px = $urandom;
    r.py = $urandom;
    r.ux = $urandom;
    r.uy = $urandom;
    r.vx = $urandom;
    r.vy = $urandom;
    r.dw = $urandom;
    r.lref = $urandom;
    return r;
  endfunction

  task automatic wr_depth(int x, int y, logic [17:0] dw);
    req_t r;
    int xx, yy;
    xx = x & 255;
    yy = y & 255;
    r = rand_req();
    r.op = dfpc_pkg::OP_DEPTH;
    r.px = xx;
    r.py = yy;
    r.dw = dw;
    depth_mem[yy * 256 + xx] = clip16(dw);
    depth_wr[yy * 256 + xx] = 1;
    pending_q.push_back(r);
  endtask

  task automatic wr_node(int t, int idx, logic [23:0] ux, logic [23:0] uy, logic [23:0] vx,
                         logic [23:0] vy, logic [17:0] thr, logic [11:0] lref);
    req_t r;
    r = rand_req();
    r.op = dfpc_pkg::OP_NODE;
    r.tsel = t;
    r.idx = idx;
    r.ux = ux;
    r.uy = uy;
    r.vx = vx;
    r.vy = vy;
    r.dw = thr;
    r.lref = lref;
    node_mem[t][idx].ux = int'($signed(ux));
    node_mem[t][idx].uy = int'($signed(uy));
    node_mem[t][idx].vx = int'($signed(vx));
    node_mem[t][idx].vy = int'($signed(vy));
    node_mem[t][idx].thr = int'($signed(thr));
    node_mem[t][idx].lref = lref;
    node_wr[t][idx] = 1;
    pending_q.push_back(r);
  endtask

  task automatic wr_prob(int t, int idx, int lab, logic [17:0] dw);
    req_t r;
    int lb;
    lb = lab & 31;
    r = rand_req();
    r.op = dfpc_pkg::OP_LEAF;
    r.tsel = t;
    r.idx = idx;
    r.lsel = lb;
    r.dw = dw;
    // leaf numbers past the table are dropped by the block
    if (idx < 2048) begin
      prob_mem[t][idx][lb] = clip16(dw);
      prob_wr[t][idx][lb] = 1;
    end
    pending_q.push_back(r);
  endtask

  task automatic try_classify(int x, int y);
    req_t r;
    longint unsigned sums[32];
    bit over;
    score_t s;
    int nt, nl, l;
    r = rand_req();
    r.op = dfpc_pkg::OP_CLASSIFY;
    r.px = x;
    r.py = y;
    if (forest_eval(x, y, sums, over)) begin
      nt = (r_tc < 1) ? 1 : (r_tc > 4) ? 4 : r_tc;
      nl = (r_lc < 1) ? 1 : (r_lc > 32) ? 32 : r_lc;
      for (l = 0; l < nl; l++) begin
        s.label = l;
        s.prob = 16'(sums[l] / nt);
        s.last = (l == nl - 1);
        s.over = over;
        score_q.push_back(s);
      end
      pending_q.push_back(r);
    end
  endtask

  function automatic logic [23:0] rand_off(int scale);
    if (scale == 0) return 24'd0;
    if ($urandom_range(0, 15) == 0) return $urandom;
    return 24'(int'($urandom_range(0, 2 * scale)) - scale);
  endfunction

  function automatic logic [17:0] rand_thr();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return 18'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic logic [17:0] rand_prob();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic [11:0] pick_leaf(int t);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(2049, 4095);
    if (r == 1) return 12'd2048;
    return 2 * t + 1 + (r & 1);
  endfunction

  task automatic build_tree(int t, int lv, int scale);
    int i;
    for (i = 0; i < (1 << lv) - 1; i++)
      wr_node(t, i, rand_off(scale), rand_off(scale), rand_off(scale), rand_off(scale),
              rand_thr(), 12'd0);
    for (i = (1 << lv) - 1; i < (1 << (lv + 1)) - 1; i++)
      wr_node(t, i, $urandom, $urandom, $urandom, $urandom, $urandom, pick_leaf(t));
  endtask

  // right spine with the lowest threshold: every step goes right, off the end
  task automatic build_spine(int t);
    int id;
    id = 0;
    repeat (12) begin
      wr_node(t, id, 0, 0, 0, 0, 18'h20000, 12'd0);
      id = 2 * id + 2;
    end
  endtask

  task automatic pick_classify();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) try_classify($urandom_range(0, 7), $urandom_range(0, 7));
    else if (r == 8) try_classify(255, 255);
    else try_classify(128, 0);
  endtask

  task automatic wr_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      dfpc_pkg::REG_FRAME_WIDTH:  r_w = val & 16'h1FF;
      dfpc_pkg::REG_FRAME_HEIGHT: r_h = val & 16'h1FF;
      dfpc_pkg::REG_LABEL_COUNT:  r_lc = val & 16'h3F;
      dfpc_pkg::REG_TREE_COUNT:   r_tc = val & 16'h7;
      dfpc_pkg::REG_BACKGROUND:   r_bg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_regs(int w, int h, int lc, int tc, int bg);
    wr_reg(dfpc_pkg::REG_FRAME_WIDTH, w);
    wr_reg(dfpc_pkg::REG_FRAME_HEIGHT, h);
    wr_reg(dfpc_pkg::REG_LABEL_COUNT, lc);
    wr_reg(dfpc_pkg::REG_TREE_COUNT, tc);
    wr_reg(dfpc_pkg::REG_BACKGROUND, bg);
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending_q.size() != 0 || s_axis_tvalid || score_q.size() != 0) @(negedge clk);
    // writes after the last score may still be in flight
    repeat (40) @(negedge clk);
  endtask

  task automatic random_mix(int n);
    int r, t;
    repeat (n) begin
      r = $urandom_range(0, 9);
      t = $urandom_range(0, 3);
      case (r)
        0: wr_depth($urandom, $urandom, $urandom);
        1: wr_depth($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 4000));
        2: if ($urandom_range(0, 3) == 0)
             wr_prob(t, $urandom_range(2048, 4095), $urandom, $urandom);
           else wr_prob(t, pick_leaf(t) % 4096 - 1 < 2048 ? 2 * t + $urandom_range(0, 1) : 2047,
                        $urandom, rand_prob());
        3: wr_node(t, $urandom_range(0, 14), rand_off(20000), rand_off(20000), rand_off(20000),
                   rand_off(20000), rand_thr(),
                   ($urandom_range(0, 1) != 0) ? pick_leaf(t) : 12'd0);
        default: pick_classify();
      endcase
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_q.size() != 0 &&
          !(idle_mode == 0 && $urandom_range(0, 99) < 23) &&
          !(idle_mode == 1 && $urandom_range(0, 99) < 73)) begin
        req_t r;
        r = pending_q.pop_front();
        s_axis_tvalid <= 1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {7'd0, r.lref, r.dw, r.vy, r.vx, r.uy, r.ux, r.py, r.px, r.lsel,
                         r.idx, r.tsel};
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // receiver and score check
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (score_q.size() == 0) begin
          if (errors < 10) $display("unexpected score item: tdata=%h", m_axis_tdata);
          errors++;
        end else begin
          score_t e;
          e = score_q.pop_front();
          if (m_axis_tdata[4:0] !== e.label || m_axis_tdata[20:5] !== e.prob ||
              m_axis_tlast !== e.last || m_axis_tuser !== e.over) begin
            if (errors < 10)
              $display({"score mismatch: exp label=%0d prob=%0d last=%b over=%b, ",
                        "got label=%0d prob=%0d last=%b over=%b"},
                       e.label, e.prob, e.last, e.over, m_axis_tdata[4:0],
                       m_axis_tdata[20:5], m_axis_tlast, m_axis_tuser);
            errors++;
          end
        end
      end
      if (hold_ticket != hold_seen) begin
        hold_seen <= hold_ticket;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= !((idle_mode == 0 && $urandom_range(0, 99) < 73) ||
                           (idle_mode == 1 && $urandom_range(0, 99) < 23));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall <= 0;
      end else begin
        stall <= stall + 1;
        if (stall >= STALL_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int x, y, t, l, k;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: load everything under reset settings, probes on the centre pixel
    for (y = 0; y < 8; y++)
      for (x = 0; x < 8; x++)
        wr_depth(x, y, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(300, 4000));
    wr_depth(0, 0, 18'd0);           // zero centre depth
    wr_depth(255, 255, 18'h1FFFF);   // saturates high
    wr_depth(128, 0, 18'h20000);     // saturates to zero
    for (t = 0; t < 4; t++) build_tree(t, 2, 0);
    for (t = 0; t < 4; t++)
      for (l = 0; l < 32; l++) begin
        wr_prob(t, 2 * t, l, rand_prob());
        wr_prob(t, 2 * t + 1, l, rand_prob());
        wr_prob(t, 2047, l, (l == 0) ? 18'h3FFFF : (l == 1) ? 18'h1FFFF : rand_prob());
      end
    wr_prob(0, 12'hFFF, 31, 18'h0FFFF);  // leaf past the table, dropped
    try_classify(0, 0);
    try_classify(7, 7);
    try_classify(3, 4);
    try_classify(255, 255);
    try_classify(128, 0);
    settle();

    // small frame, walk overrun in one tree
    set_regs(8, 8, 32, 4, $urandom);
    build_tree(0, 3, 20000);
    build_spine(1);
    build_tree(2, 3, 20000);
    build_tree(3, 1, 20000);
    try_classify(2, 2);
    try_classify(255, 255);          // centre outside the frame
    repeat (15) pick_classify();
    settle();

    // frame of zero size: every probe is off the frame
    set_regs(0, 0, 1, 1, 0);
    repeat (8) pick_classify();
    settle();

    idle_mode = 1;
    set_regs(511, 511, 63, 7, 65535);
    for (t = 0; t < 4; t++) build_tree(t, 2, 3000);
    repeat (20) pick_classify();
    settle();

    set_regs(1, 256, 0, 0, $urandom);
    build_tree(0, 0, 0);             // root is a leaf
    repeat (10) pick_classify();
    settle();

    for (k = 0; k < 10; k++) begin
      idle_mode = (k < 3) ? 1 : 2;
      set_regs($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 32),
               $urandom_range(1, 4), $urandom);
      build_tree($urandom_range(0, 3), $urandom_range(0, 4), 20000);
      if ($urandom_range(0, 3) == 0) build_spine($urandom_range(0, 3));
      else build_tree($urandom_range(0, 3), $urandom_range(1, 3), 20000);
      if (k == 5) hold_ticket = hold_ticket + 1;
      random_mix(12);
      settle();
    end

    idle_mode = 0;
    random_mix(12);
    settle();
    repeat (100) @(negedge clk);
    if (errors == 0 && score_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
